// File: hdl/ple_pkg.sv
// Shared types and constants of the positional list engine.
`default_nettype none

package ple_pkg;

  // Default sizes of the list store.
  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned ItemWidthDef = 32;

  // Fixed widths of the item fields at the ports.
  localparam int unsigned ActionW  = 2;
  localparam int unsigned PosW     = 5;
  localparam int unsigned ItemPortW = 32;
  localparam int unsigned LenOutW  = 5;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_RETRIEVE = 2'd2
  } ple_action_e;

  // Broadcast from the control logic to every cell of the chain.
  typedef struct packed {
    logic            ins;      // open a slot at pos_idx, shift later cells back
    logic            rem;      // close the slot at pos_idx, shift later cells forward
    logic [PosW-1:0] pos_idx;  // zero-based position of the action
  } ple_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/ple_cell.sv
// One storage cell of the list chain, holding a single entry.
`default_nettype none

module ple_cell #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned DataW = 32
) (
  input  logic                clk_i,
  input  ple_pkg::ple_ctrl_t  ctrl_i,
  input  logic [DataW-1:0]    item_wr_i,
  input  logic [DataW-1:0]    left_i,
  input  logic [DataW-1:0]    right_i,
  output logic [DataW-1:0]    data_o
);
  import ple_pkg::*;

  logic [DataW-1:0] data_q;
  logic [DataW-1:0] data_d;
  logic [31:0]      pos_ext;
  logic             is_at;
  logic             is_after;

  assign pos_ext  = 32'(ctrl_i.pos_idx);
  assign is_at    = (pos_ext == 32'(Idx));
  assign is_after = (pos_ext < 32'(Idx));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (is_after) begin
        data_d = left_i;
      end else if (is_at) begin
        data_d = item_wr_i;
      end
    end else if (ctrl_i.rem) begin
      if (is_at || is_after) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: hdl/positional_list_engine_core.sv
// Top level of the positional list engine: control, cell chain and result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------
//   in      | sink      | in_valid_i, in_stall_o | action_i, position_i, item_in_i
//   out     | source    | out_valid_o, out_stall_i | ok_o, item_out_o, list_length_o
//
// The whole chain of cells shifts in the cycle the item is accepted, so a new item
// can be taken in every cycle unless the input stalls.
// The result is registered in the output register when the item is accepted.
// The input stalls only while a finished result is held and the output is stalled.
// Reset clears the length and the output valid; entry contents are left undefined,
// since only positions up to the current length are ever read.
`default_nettype none

module positional_list_engine_core #(
  parameter int unsigned Capacity  = ple_pkg::CapacityDef,
  parameter int unsigned ItemWidth = ple_pkg::ItemWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ple_pkg::ActionW-1:0]        action_i,
  input  logic [ple_pkg::PosW-1:0]           position_i,
  input  logic [ple_pkg::ItemPortW-1:0]      item_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               ok_o,
  output logic [ple_pkg::ItemPortW-1:0]      item_out_o,
  output logic [ple_pkg::LenOutW-1:0]        list_length_o
);
  import ple_pkg::*;

  // Only the low bits of an item that fit both the store and the port survive.
  localparam int unsigned DataW = (ItemWidth < ItemPortW) ? ItemWidth : ItemPortW;
  // Width of the length counter, able to hold the capacity itself.
  localparam int unsigned LenW  = $clog2(Capacity + 1);
  // Common compare width for position and length, with room for length plus one.
  localparam int unsigned CmpW  = ((LenW > PosW) ? LenW : PosW) + 1;
  // A 5-bit position reaches at most this many cells.
  localparam int unsigned PosMax = (1 << PosW) - 1;
  localparam int unsigned ReadN  = (Capacity < PosMax) ? Capacity : PosMax;

  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  len_d;
  logic             out_valid_q;
  logic             ok_q;
  logic             ok_d;
  logic [ItemPortW-1:0] item_out_q;
  logic [ItemPortW-1:0] item_out_d;
  logic [LenOutW-1:0]   len_out_q;
  logic [CmpW-1:0]  len_next_w;

  logic             in_acc;
  logic [CmpW-1:0]  pos_w;
  logic [CmpW-1:0]  len_w;
  logic             pos_nz;
  logic             ins_ok;
  logic             rd_ok;
  logic [DataW-1:0] rd_data;
  logic [DataW-1:0] item_wr;

  ple_ctrl_t        ctrl;
  logic [DataW-1:0] cell_data [Capacity];

  // The output register frees up in the same cycle it is drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_w  = CmpW'(position_i);
  assign len_w  = CmpW'(len_q);
  assign pos_nz = (position_i != '0);
  // Insert may land one past the tail, but never into a full list.
  assign ins_ok = pos_nz && (pos_w <= len_w + CmpW'(1)) && (len_w < CmpW'(Capacity));
  // Remove and retrieve need an existing entry.
  assign rd_ok  = pos_nz && (pos_w <= len_w);

  assign item_wr = item_in_i[DataW-1:0];

  always_comb begin
    ctrl.ins     = 1'b0;
    ctrl.rem     = 1'b0;
    ctrl.pos_idx = position_i - PosW'(1);
    ok_d         = 1'b0;
    item_out_d   = '0;
    len_d        = len_q;
    case (action_i)
      ACT_INSERT: begin
        if (ins_ok) begin
          ctrl.ins = in_acc;
          ok_d     = 1'b1;
          len_d    = len_q + LenW'(1);
        end
      end
      ACT_REMOVE: begin
        if (rd_ok) begin
          ctrl.rem = in_acc;
          ok_d     = 1'b1;
          len_d    = len_q - LenW'(1);
        end
      end
      ACT_RETRIEVE: begin
        if (rd_ok) begin
          ok_d = 1'b1;
          item_out_d[DataW-1:0] = rd_data;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Read port: only the cells a 5-bit position can reach take part.
  always_comb begin
    rd_data = '0;
    for (int unsigned i = 0; i < ReadN; i++) begin
      if (ctrl.pos_idx == PosW'(i)) begin
        rd_data = rd_data | cell_data[i];
      end
    end
  end

  // The chain: each cell takes its left neighbor on an insert before it and its
  // right neighbor on a remove at or before it. The ends see zero.
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [DataW-1:0] left;
    logic [DataW-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    ple_cell #(
      .Idx   (g),
      .DataW (DataW)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .item_wr_i (item_wr),
      .left_i    (left),
      .right_i   (right),
      .data_o    (cell_data[g])
    );
  end

  assign len_next_w = CmpW'(len_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        len_q       <= len_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ok_q       <= ok_d;
      item_out_q <= item_out_d;
      len_out_q  <= len_next_w[LenOutW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign item_out_o    = item_out_q;
  assign list_length_o = len_out_q;

`ifndef SYNTH
  // The length never grows past the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(Capacity))
    else $error("list length exceeds capacity");

  // A failed action leaves the length untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !ok_d |=> len_q == $past(len_q))
    else $error("failed action changed the length");

  // A successful insert grows the list by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ctrl.ins |=> len_q == $past(len_q) + LenW'(1))
    else $error("insert did not grow the list by one");

  // A failed result never carries item data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> item_out_o == '0)
    else $error("failed result carries item data");
`endif

endmodule

`default_nettype wire
